// File: src/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared types and constants: stage encoding, configuration and state
// records, fixed-point limits and register map.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEVEL_W = 24;
    localparam int FACTOR_W = 24;
    localparam int CODE_W = 3;

    // Q1.23 full scale and the snap distance (0.0001 in Q1.23)
    localparam logic [LEVEL_W-1:0] FULL_SCALE = 24'd8388608;
    localparam logic [LEVEL_W-1:0] SNAP_THRESHOLD = 24'd839;

    // register reset values
    localparam logic [LEVEL_W-1:0] ATTACK_STEP_RST = 24'd17476;
    localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST = 24'd16773721;
    localparam logic [LEVEL_W-1:0] SUSTAIN_TARGET_RST = 24'd5872026;
    localparam logic [FACTOR_W-1:0] RELEASE_FACTOR_RST = 24'd16776051;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ATTACK_STEP = 2'd0;
    localparam logic [1:0] REG_DECAY_FACTOR = 2'd1;
    localparam logic [1:0] REG_SUSTAIN_TARGET = 2'd2;
    localparam logic [1:0] REG_RELEASE_FACTOR = 2'd3;

    // external stage codes
    localparam logic [CODE_W-1:0] CODE_IDLE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ATTACK = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DECAY = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_ATTACK  = 5'b00010,
        ST_DECAY   = 5'b00100,
        ST_SUSTAIN = 5'b01000,
        ST_RELEASE = 5'b10000
    } stage_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  attack_step;
        logic [FACTOR_W-1:0] decay_factor;
        logic [LEVEL_W-1:0]  sustain_target;
        logic [FACTOR_W-1:0] release_factor;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        stage_t             stage;
        logic               gate_prev;
    } env_state_t;

    function automatic logic [CODE_W-1:0] stage_code(input stage_t st);
        logic [CODE_W-1:0] code;
        case (st)
            ST_ATTACK:  code = CODE_ATTACK;
            ST_DECAY:   code = CODE_DECAY;
            ST_SUSTAIN: code = CODE_SUSTAIN;
            ST_RELEASE: code = CODE_RELEASE;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: src/adsr_level_update.sv
// ----------------------------------------------------------------------------
// ADSR level update
// Next level, stage and gate history for one gate sample. One shared
// 24x24 multiplier serves both decay and release.
// ----------------------------------------------------------------------------
module adsr_level_update (
    input  logic                 gate_on,
    input  adsr_pkg::cfg_t       cfg,
    input  adsr_pkg::env_state_t cur,
    output adsr_pkg::env_state_t nxt
);

    adsr_pkg::stage_t                  stage_pre;
    logic [adsr_pkg::LEVEL_W:0]        attack_sum;
    logic                              above_sustain;
    logic [adsr_pkg::LEVEL_W-1:0]      mul_a;
    logic [adsr_pkg::FACTOR_W-1:0]     mul_b;
    logic [adsr_pkg::LEVEL_W+adsr_pkg::FACTOR_W-1:0] product;
    logic [adsr_pkg::LEVEL_W-1:0]      scaled;
    logic [adsr_pkg::LEVEL_W:0]        decay_sum;

    // gate edges override the held stage
    always_comb begin
        stage_pre = cur.stage;
        if (gate_on && !cur.gate_prev) begin
            stage_pre = adsr_pkg::ST_ATTACK;
        end else if (!gate_on && cur.gate_prev) begin
            stage_pre = adsr_pkg::ST_RELEASE;
        end
    end

    assign attack_sum = {1'b0, cur.level} + {1'b0, cfg.attack_step};
    assign above_sustain = cur.level > cfg.sustain_target;

    // decay scales the distance above sustain, release scales the level
    always_comb begin
        if (stage_pre == adsr_pkg::ST_DECAY) begin
            mul_a = above_sustain ? (cur.level - cfg.sustain_target) : '0;
            mul_b = cfg.decay_factor;
        end else begin
            mul_a = cur.level;
            mul_b = cfg.release_factor;
        end
    end

    assign product = {{adsr_pkg::FACTOR_W{1'b0}}, mul_a} * {{adsr_pkg::LEVEL_W{1'b0}}, mul_b};
    assign scaled = product[adsr_pkg::LEVEL_W+adsr_pkg::FACTOR_W-1:adsr_pkg::FACTOR_W];
    assign decay_sum = {1'b0, cfg.sustain_target} + {1'b0, scaled};

    always_comb begin
        nxt.gate_prev = gate_on;
        nxt.stage = stage_pre;
        nxt.level = '0;
        case (stage_pre)
            adsr_pkg::ST_ATTACK: begin
                if (attack_sum >= {1'b0, adsr_pkg::FULL_SCALE}) begin
                    nxt.level = adsr_pkg::FULL_SCALE;
                    nxt.stage = adsr_pkg::ST_DECAY;
                end else begin
                    nxt.level = attack_sum[adsr_pkg::LEVEL_W-1:0];
                end
            end
            adsr_pkg::ST_DECAY: begin
                if (scaled < adsr_pkg::SNAP_THRESHOLD) begin
                    nxt.level = cfg.sustain_target;
                    nxt.stage = adsr_pkg::ST_SUSTAIN;
                end else begin
                    nxt.level = decay_sum[adsr_pkg::LEVEL_W-1:0];
                end
            end
            adsr_pkg::ST_SUSTAIN: begin
                nxt.level = cfg.sustain_target;
            end
            adsr_pkg::ST_RELEASE: begin
                if (scaled < adsr_pkg::SNAP_THRESHOLD) begin
                    nxt.level = '0;
                    nxt.stage = adsr_pkg::ST_IDLE;
                end else begin
                    nxt.level = scaled;
                end
            end
            default: begin
                nxt.level = '0;
            end
        endcase
    end

endmodule

// File: src/adsr_envelope_generator_unit.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator unit
// Linear attack, exponential decay and release envelope, one gate sample
// in and one level/stage item out per audio tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one gate sample per item, s_tdata[23:0] signed; the gate is
//   on when the sample is above zero. A rising gate starts attack, a
//   falling gate starts release.
//   m_ channel: one item per input item, m_tdata[23:0] the level (Q1.23)
//   and m_tdata[26:24] the stage (0 idle, 1 attack, 2 decay, 3 sustain,
//   4 release).
//   APB port: four 24-bit registers at byte addresses 0, 4, 8 and 12
//   (attack step, decay factor, sustain target, release factor). Write
//   them only while no item is in flight.
// Pipeline and throughput: an item is registered on entry, and its result is
//   then registered in the output register.
//   One item is taken every cycle while the output is not stalled; the level
//   feedback through the single 24x24 multiply is combinational.
// Reset: the level returns to zero, the stage to idle, the gate history to
//   off and the registers to their defaults. Both channels run empty.
// Stall: while m_tready is low the result is held, the entry stage fills
//   and then s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] gate_level
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [23:0] envelope_level, [26:24] envelope_stage
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    adsr_pkg::cfg_t        cfg_reg;
    adsr_pkg::env_state_t  state_reg;
    adsr_pkg::env_state_t  state_next;

    logic                  in_valid_reg;
    logic [23:0]           gate_reg;
    logic                  out_valid_reg;
    logic [23:0]           out_level_reg;
    logic [2:0]            out_code_reg;

    logic                  gate_on;
    logic                  advance;
    logic                  cfg_write;
    logic [1:0]            reg_index;

    assign pready = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers: bits above 23 are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_step <= adsr_pkg::ATTACK_STEP_RST;
            cfg_reg.decay_factor <= adsr_pkg::DECAY_FACTOR_RST;
            cfg_reg.sustain_target <= adsr_pkg::SUSTAIN_TARGET_RST;
            cfg_reg.release_factor <= adsr_pkg::RELEASE_FACTOR_RST;
        end else if (cfg_write) begin
            case (reg_index)
                adsr_pkg::REG_ATTACK_STEP:    cfg_reg.attack_step <= pwdata[23:0];
                adsr_pkg::REG_DECAY_FACTOR:   cfg_reg.decay_factor <= pwdata[23:0];
                adsr_pkg::REG_SUSTAIN_TARGET: cfg_reg.sustain_target <= pwdata[23:0];
                adsr_pkg::REG_RELEASE_FACTOR: cfg_reg.release_factor <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            adsr_pkg::REG_ATTACK_STEP:    prdata = {8'd0, cfg_reg.attack_step};
            adsr_pkg::REG_DECAY_FACTOR:   prdata = {8'd0, cfg_reg.decay_factor};
            adsr_pkg::REG_SUSTAIN_TARGET: prdata = {8'd0, cfg_reg.sustain_target};
            adsr_pkg::REG_RELEASE_FACTOR: prdata = {8'd0, cfg_reg.release_factor};
            default:                      prdata = '0;
        endcase
    end

    // advance the entry stage whenever the output register is free or drains
    assign advance = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            gate_reg <= s_tdata;
        end
    end

    assign gate_on = !gate_reg[23] && (gate_reg != 24'd0);

    adsr_level_update u_update (
        .gate_on (gate_on),
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .nxt     (state_next)
    );

    // envelope state moves only when an item is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.level <= '0;
            state_reg.stage <= adsr_pkg::ST_IDLE;
            state_reg.gate_prev <= 1'b0;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_level_reg <= state_next.level;
            out_code_reg <= adsr_pkg::stage_code(state_next.stage);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {5'd0, out_code_reg, out_level_reg};

endmodule

// File: tb/sv/adsr_envelope_checker.sv
// ----------------------------------------------------------------------------
// ADSR envelope checker
// Watches the gate, result and register channels of the envelope unit,
// predicts the level and stage of every accepted gate item and compares
// each accepted result with the oldest prediction. Register writes seen on
// the APB port update the predictor's settings; reads are checked against
// them.
// ----------------------------------------------------------------------------
module adsr_envelope_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] gate_level
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [23:0] envelope_level, [26:24] envelope_stage
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          results_owed
);

    typedef struct packed {
        logic [adsr_pkg::LEVEL_W-1:0] level;
        logic [adsr_pkg::CODE_W-1:0]  stage;
    } envelope_item_t;

    // predicted results still to arrive, oldest first
    envelope_item_t envelope_due[$];

    adsr_pkg::cfg_t               settings;
    logic [adsr_pkg::LEVEL_W-1:0] level_q;
    logic [adsr_pkg::CODE_W-1:0]  stage_q;
    logic                         gate_prev_q;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Advance the envelope by one gate sample and return the new level/stage.
    task automatic step_envelope(input logic [23:0] gate, output envelope_item_t res);
        logic                         gate_on;
        logic [24:0]                  sum;
        logic [47:0]                  prod;
        logic [adsr_pkg::LEVEL_W-1:0] part;
        gate_on = !gate[23] && (gate != '0);
        if (gate_on && !gate_prev_q)
            stage_q = adsr_pkg::CODE_ATTACK;
        if (!gate_on && gate_prev_q)
            stage_q = adsr_pkg::CODE_RELEASE;
        gate_prev_q = gate_on;
        case (stage_q)
            adsr_pkg::CODE_ATTACK: begin
                sum = {1'b0, level_q} + {1'b0, settings.attack_step};
                if (sum >= {1'b0, adsr_pkg::FULL_SCALE}) begin
                    level_q = adsr_pkg::FULL_SCALE;
                    stage_q = adsr_pkg::CODE_DECAY;
                end else begin
                    level_q = sum[23:0];
                end
            end
            adsr_pkg::CODE_DECAY: begin
                prod = '0;
                if (level_q > settings.sustain_target)
                    prod = {24'd0, level_q - settings.sustain_target}
                           * {24'd0, settings.decay_factor};
                part = prod[47:24];
                if (part < adsr_pkg::SNAP_THRESHOLD) begin
                    level_q = settings.sustain_target;
                    stage_q = adsr_pkg::CODE_SUSTAIN;
                end else begin
                    level_q = settings.sustain_target + part;
                end
            end
            adsr_pkg::CODE_SUSTAIN: begin
                level_q = settings.sustain_target;
            end
            adsr_pkg::CODE_RELEASE: begin
                prod = {24'd0, level_q} * {24'd0, settings.release_factor};
                part = prod[47:24];
                if (part < adsr_pkg::SNAP_THRESHOLD) begin
                    level_q = '0;
                    stage_q = adsr_pkg::CODE_IDLE;
                end else begin
                    level_q = part;
                end
            end
            default: begin
                level_q = '0;
            end
        endcase
        res.level = level_q;
        res.stage = stage_q;
    endtask

    always @(posedge aclk) begin
        envelope_item_t want;
        envelope_item_t next;
        logic [23:0]    reg_value;
        if (!aresetn) begin
            settings.attack_step    = adsr_pkg::ATTACK_STEP_RST;
            settings.decay_factor   = adsr_pkg::DECAY_FACTOR_RST;
            settings.sustain_target = adsr_pkg::SUSTAIN_TARGET_RST;
            settings.release_factor = adsr_pkg::RELEASE_FACTOR_RST;
            level_q     = '0;
            stage_q     = adsr_pkg::CODE_IDLE;
            gate_prev_q = 1'b0;
            envelope_due.delete();
            results_owed <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (envelope_due.size() == 0) begin
                    report_mismatch("result with nothing owed", m_tdata, '0);
                end else begin
                    want = envelope_due.pop_front();
                    if (m_tdata[23:0] !== want.level)
                        report_mismatch("envelope_level", 32'(m_tdata[23:0]),
                                        32'(want.level));
                    if (m_tdata[26:24] !== want.stage)
                        report_mismatch("envelope_stage", 32'(m_tdata[26:24]),
                                        32'(want.stage));
                end
            end
            if (s_tvalid && s_tready) begin
                step_envelope(s_tdata, next);
                envelope_due.push_back(next);
            end
            if (psel && penable && pready) begin
                case (paddr[3:2])
                    adsr_pkg::REG_ATTACK_STEP:    reg_value = settings.attack_step;
                    adsr_pkg::REG_DECAY_FACTOR:   reg_value = settings.decay_factor;
                    adsr_pkg::REG_SUSTAIN_TARGET: reg_value = settings.sustain_target;
                    default:                      reg_value = settings.release_factor;
                endcase
                if (pwrite) begin
                    // bits above the register width are dropped
                    case (paddr[3:2])
                        adsr_pkg::REG_ATTACK_STEP:
                            settings.attack_step = pwdata[23:0];
                        adsr_pkg::REG_DECAY_FACTOR:
                            settings.decay_factor = pwdata[23:0];
                        adsr_pkg::REG_SUSTAIN_TARGET:
                            settings.sustain_target = pwdata[23:0];
                        default:
                            settings.release_factor = pwdata[23:0];
                    endcase
                end else if (prdata[23:0] !== reg_value) begin
                    report_mismatch("register read", 32'(prdata[23:0]), 32'(reg_value));
                end
            end
            results_owed <= envelope_due.size();
        end
    end

endmodule

// File: tb/sv/tb_adsr_envelope_generator_unit.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator unit testbench
// Drives gate items and register settings into the envelope unit, with
// phases of random sender gaps and receiver stalls. A checker beside the
// unit predicts every result; this module gives the verdict from its
// mismatch count.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_generator_unit;

    localparam logic [23:0] GATE_MAX = 24'h7FFFFF;     // largest positive sample
    localparam logic [23:0] GATE_MIN = 24'h800000;     // most negative sample
    localparam logic [23:0] GATE_NEG_ONE = 24'hFFFFFF;
    localparam logic [23:0] WORD_MAX = 24'hFFFFFF;
    localparam int PHRASE_ITEMS = 60;
    localparam int PHRASE_COUNT = 18;

    typedef enum {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [23:0] gate_level
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [23:0] envelope_level, [26:24] envelope_stage
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int results_owed;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    adsr_envelope_generator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    adsr_envelope_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall at random at the rate the current phase sets.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Choose how often each side idles.
    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SENDER: begin
                tx_idle_pct  = 86;
                rx_stall_pct = 0;
            end
            PACE_RECEIVER: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 86;
            end
            PACE_BOTH: begin
                tx_idle_pct  = 28;
                rx_stall_pct = 28;
            end
            default: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    // Offer one gate item, after a random gap, and hold it until it is taken.
    task automatic send_gate(input logic [23:0] gate);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= gate;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop valid and wait until every owed result has come out, then let the
    // pipeline settle before any register is touched.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    // One APB transfer: setup phase, access phase, then back to idle.
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write a register with junk in the unused top byte, then read it back.
    task automatic write_register(input logic [1:0] idx, input logic [23:0] value);
        apb_access(1'b1, idx, {8'($urandom), value});
        apb_access(1'b0, idx, '0);
    endtask

    task automatic load_settings(input logic [23:0] step, input logic [23:0] decay,
                                 input logic [23:0] sustain, input logic [23:0] rel);
        write_register(adsr_pkg::REG_ATTACK_STEP, step);
        write_register(adsr_pkg::REG_DECAY_FACTOR, decay);
        write_register(adsr_pkg::REG_SUSTAIN_TARGET, sustain);
        write_register(adsr_pkg::REG_RELEASE_FACTOR, rel);
    endtask

    // Mostly fast envelopes so the stages turn over within a phrase; now and
    // then an extreme value.
    function automatic logic [23:0] random_register(input logic [1:0] idx);
        int pick;
        logic [23:0] value;
        pick = $urandom_range(15);
        case (idx)
            adsr_pkg::REG_ATTACK_STEP: begin
                if (pick < 2)       value = 24'd1;
                else if (pick < 4)  value = adsr_pkg::FULL_SCALE;
                else if (pick == 4) value = WORD_MAX;
                else                value = 24'($urandom_range(8388608, 300000));
            end
            adsr_pkg::REG_SUSTAIN_TARGET: begin
                if (pick < 2)       value = '0;
                else if (pick < 4)  value = adsr_pkg::FULL_SCALE;
                else if (pick == 4) value = WORD_MAX;
                else                value = 24'($urandom_range(8388608, 0));
            end
            default: begin
                if (pick < 2)       value = '0;
                else if (pick < 4)  value = WORD_MAX;
                else                value = 24'($urandom_range(14000000, 0));
            end
        endcase
        return value;
    endfunction

    function automatic logic [23:0] gate_on_value();
        case ($urandom_range(7))
            0:       return 24'd1;
            1:       return GATE_MAX;
            default: return 24'($urandom_range(8388607, 1));
        endcase
    endfunction

    function automatic logic [23:0] gate_off_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return GATE_MIN;
            2:       return GATE_NEG_ONE;
            default: return {1'b1, 23'($urandom)};
        endcase
    endfunction

    // Alternate runs of gate-on and gate-off samples; about one item in ten is
    // raw noise across the whole 24-bit range.
    task automatic play_phrases(input int count);
        int  sent;
        int  run;
        int  k;
        bit  gate_high;
        sent = 0;
        gate_high = 1'b1;
        while (sent < count) begin
            run = gate_high ? $urandom_range(40, 1) : $urandom_range(25, 1);
            for (k = 0; k < run && sent < count; k++) begin
                if ($urandom_range(9) == 0)
                    send_gate(24'($urandom));
                else
                    send_gate(gate_high ? gate_on_value() : gate_off_value());
                sent++;
            end
            gate_high = !gate_high;
        end
    endtask

    initial begin
        int phrase;
        set_pace(PACE_FREE);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default settings: idle at both gate extremes, a slow attack from a
        // rising gate, then release on a falling one.
        send_gate('0);
        send_gate(GATE_MIN);
        send_gate(24'd1);
        send_gate(GATE_MAX);
        send_gate('0);
        send_gate(GATE_NEG_ONE);
        wait_drained();

        // Full-scale step saturates at once; sustain above full scale snaps
        // in decay; zero release drops straight to idle.
        load_settings(adsr_pkg::FULL_SCALE, WORD_MAX, WORD_MAX, '0);
        send_gate(24'd1);
        send_gate(GATE_MAX);
        send_gate(24'd77);
        send_gate('0);
        send_gate(GATE_MIN);
        wait_drained();

        // Zero attack step holds the level in attack; release below the snap
        // distance goes idle.
        load_settings('0, '0, '0, WORD_MAX);
        send_gate(24'd5);
        send_gate(24'd100);
        send_gate(GATE_NEG_ONE);
        wait_drained();

        // Whole shape: two attack ticks, decay snapping to sustain, sustain,
        // then halving in release.
        load_settings(24'd4194304, 24'h100000, 24'd4194304, 24'd8388608);
        repeat (7) send_gate(GATE_MAX);
        send_gate('0);
        send_gate(GATE_MIN);
        wait_drained();

        // Random phrases, cycling through the idling phases with fresh settings.
        for (phrase = 0; phrase < PHRASE_COUNT; phrase++) begin
            set_pace(pace_t'(phrase % 4));
            load_settings(random_register(adsr_pkg::REG_ATTACK_STEP),
                          random_register(adsr_pkg::REG_DECAY_FACTOR),
                          random_register(adsr_pkg::REG_SUSTAIN_TARGET),
                          random_register(adsr_pkg::REG_RELEASE_FACTOR));
            play_phrases(PHRASE_ITEMS);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: a correct run ends long before this.
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: adsr_envelope_generator_unit.f
src/adsr_pkg.sv
src/adsr_level_update.sv
src/adsr_envelope_generator_unit.sv
tb/sv/adsr_envelope_checker.sv
tb/sv/tb_adsr_envelope_generator_unit.sv
